// ===== rtl/fss_pkg.sv =====
// Constants, codes and helper functions for the fuzzy subsequence scorer.
`timescale 1ns / 1ps

package fss_pkg;

   localparam int MAX_PATTERN_DEF = 16;

   localparam int BYTE_W   = 8;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 64;
   localparam int LEN_W    = 5;
   localparam int RUN_W    = 5;
   localparam int SCORE_W  = 10;
   localparam int RESULT_W = 11;
   localparam int ADD_W    = 8;

   localparam int SCORE_MATCH = 10;
   localparam int SCORE_RUN   = 5;
   localparam int SCORE_SEP   = 8;
   localparam int RUN_MAX     = 31;

   typedef logic [CSR_IDX_W-1:0] csr_idx_type;
   localparam csr_idx_type CSR_PATTERN_LOW    = 2'd0;
   localparam csr_idx_type CSR_PATTERN_HIGH   = 2'd1;
   localparam csr_idx_type CSR_PATTERN_LENGTH = 2'd2;

   localparam logic [BYTE_W-1:0] CHR_UPPER_A = 8'h41;
   localparam logic [BYTE_W-1:0] CHR_UPPER_Z = 8'h5A;
   localparam logic [BYTE_W-1:0] CHR_CASE    = 8'h20;
   localparam logic [BYTE_W-1:0] CHR_UNDER   = 8'h5F;
   localparam logic [BYTE_W-1:0] CHR_COLON   = 8'h3A;
   localparam logic [BYTE_W-1:0] CHR_SPACE   = 8'h20;
   localparam logic [BYTE_W-1:0] CHR_TAB     = 8'h09;
   localparam logic [BYTE_W-1:0] CHR_HYPHEN  = 8'h2D;

   localparam logic signed [RESULT_W-1:0] RESULT_NO_MATCH = -11'sd1;

   function automatic logic [BYTE_W-1:0] fold_case(input logic [BYTE_W-1:0] c);
      if (c >= CHR_UPPER_A && c <= CHR_UPPER_Z) begin
         return c | CHR_CASE;
      end
      return c;
   endfunction

   function automatic logic is_separator(input logic [BYTE_W-1:0] c);
      return (c == CHR_UNDER) || (c == CHR_COLON) || (c == CHR_SPACE) ||
             (c == CHR_TAB) || (c == CHR_HYPHEN);
   endfunction

endpackage

// ===== rtl/fuzzy_subsequence_scorer_unit.sv =====
// Top level of the fuzzy subsequence scorer: streamed text bytes scored against a pattern.
//
// Usage:
//   csr_*  : pattern_low (0), pattern_high (1), pattern_length (2); csr_ready is always
//            high, writes to other indexes are dropped. Write only while the block is idle.
//   req_*  : one text byte per transfer; has_byte = 0 gives a bare end marker, and
//            end_of_text closes the text and produces one rsp transfer.
//   rsp_*  : rsp_score = match score 0..888, -1 if the pattern was not completed, 0 for
//            an empty pattern.
// Timing:
//   One transfer per cycle sustained while no end of text waits for a held result. A req
//   transfer lands in the input register and is scored from there against the text state;
//   for an end of text the result goes into the result register, which drives rsp_valid.
//   The throughput is set by the loop through the text state registers.
// Reset:
//   Clears the pattern registers, the text state and both valid flags.
// Stall:
//   While rsp_stall holds a waiting result, bytes without end_of_text keep flowing;
//   an end of text waits in the input register and req_stall rises until the result
//   register is free.
`timescale 1ns / 1ps

module fuzzy_subsequence_scorer_unit
   import fss_pkg::*;
#(
   parameter int MAX_PATTERN = MAX_PATTERN_DEF
) (
   input  logic                       clock,
   input  logic                       reset,

   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [CSR_IDX_W-1:0]       csr_index,
   input  logic [CSR_DATA_W-1:0]      csr_data,

   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [BYTE_W-1:0]          req_text_byte,
   input  logic                       req_has_byte,
   input  logic                       req_end_of_text,

   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic signed [RESULT_W-1:0] rsp_score
);

   localparam int IDX_W = $clog2(MAX_PATTERN + 1);
   localparam int PAT_W = BYTE_W * MAX_PATTERN;
   localparam int BYTES_PER_WORD = CSR_DATA_W / BYTE_W;

   // configuration
   logic [PAT_W-1:0] pattern_ff, pattern_in;
   logic [LEN_W-1:0] length_ff, length_in;
   logic [IDX_W-1:0] len_used;

   // input register
   logic              in_valid_ff, in_valid_in;
   logic [BYTE_W-1:0] in_byte_ff, in_byte_in;
   logic              in_has_ff, in_has_in;
   logic              in_eot_ff, in_eot_in;

   // text state
   logic [IDX_W-1:0]   pattern_index_ff, pattern_index_in;
   logic [RUN_W-1:0]   run_length_ff, run_length_in;
   logic [SCORE_W-1:0] running_score_ff, running_score_in;
   logic [BYTE_W-1:0]  previous_byte_ff, previous_byte_in;
   logic               at_start_ff, at_start_in;

   // result register
   logic                       rsp_valid_ff, rsp_valid_in;
   logic signed [RESULT_W-1:0] rsp_score_ff, rsp_score_in;

   logic               req_take;
   logic               item_go;
   logic [IDX_W-1:0]   step_index;
   logic [RUN_W-1:0]   step_run;
   logic [SCORE_W-1:0] step_score;
   logic [BYTE_W-1:0]  pat_byte;
   logic [ADD_W-1:0]   add_val;
   logic signed [RESULT_W-1:0] result;

   assign csr_ready = 1'b1;
   assign len_used  = (length_ff > LEN_W'(MAX_PATTERN)) ? IDX_W'(MAX_PATTERN)
                                                         : IDX_W'(length_ff);

   always_comb begin
      pattern_in = pattern_ff;
      length_in  = length_ff;
      if (csr_valid && csr_ready) begin
         for (int b = 0; b < MAX_PATTERN; b++) begin
            if (b < BYTES_PER_WORD && csr_index == CSR_PATTERN_LOW) begin
               pattern_in[BYTE_W*b +: BYTE_W] = csr_data[BYTE_W*b +: BYTE_W];
            end
            if (b >= BYTES_PER_WORD && csr_index == CSR_PATTERN_HIGH) begin
               pattern_in[BYTE_W*b +: BYTE_W] =
                  csr_data[BYTE_W*(b-BYTES_PER_WORD) +: BYTE_W];
            end
         end
         if (csr_index == CSR_PATTERN_LENGTH) begin
            length_in = csr_data[LEN_W-1:0];
         end
      end
   end

   // an end of text needs a free result register; plain bytes always go
   assign item_go   = in_valid_ff && (!in_eot_ff || !rsp_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !item_go;
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_byte_in  = in_byte_ff;
      in_has_in   = in_has_ff;
      in_eot_in   = in_eot_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
         in_byte_in  = req_text_byte;
         in_has_in   = req_has_byte;
         in_eot_in   = req_end_of_text;
      end else if (item_go) begin
         in_valid_in = 1'b0;
      end
   end

   assign pat_byte = (pattern_index_ff < IDX_W'(MAX_PATTERN))
                     ? pattern_ff[BYTE_W*pattern_index_ff +: BYTE_W] : '0;
   assign add_val  = ADD_W'(SCORE_MATCH + SCORE_RUN * run_length_ff +
                            ((at_start_ff || is_separator(previous_byte_ff)) ? SCORE_SEP : 0));

   always_comb begin
      step_index       = pattern_index_ff;
      step_run         = run_length_ff;
      step_score       = running_score_ff;
      previous_byte_in = previous_byte_ff;
      at_start_in      = at_start_ff;
      if (item_go && in_has_ff) begin
         if (pattern_index_ff < len_used) begin
            if (fold_case(in_byte_ff) == fold_case(pat_byte)) begin
               step_score = running_score_ff + SCORE_W'(add_val);
               if (run_length_ff != RUN_W'(RUN_MAX)) begin
                  step_run = run_length_ff + RUN_W'(1);
               end
               step_index = pattern_index_ff + IDX_W'(1);
            end else begin
               step_run = '0;
            end
         end
         previous_byte_in = in_byte_ff;
         at_start_in      = 1'b0;
      end

      if (len_used == '0) begin
         result = '0;
      end else if (step_index >= len_used) begin
         result = {1'b0, step_score};
      end else begin
         result = RESULT_NO_MATCH;
      end

      pattern_index_in = step_index;
      run_length_in    = step_run;
      running_score_in = step_score;
      if (item_go && in_eot_ff) begin
         pattern_index_in = '0;
         run_length_in    = '0;
         running_score_in = '0;
         previous_byte_in = '0;
         at_start_in      = 1'b1;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_score_in = rsp_score_ff;
      if (item_go && in_eot_ff) begin
         rsp_valid_in = 1'b1;
         rsp_score_in = result;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_ff       <= '0;
         length_ff        <= '0;
         in_valid_ff      <= 1'b0;
         pattern_index_ff <= '0;
         run_length_ff    <= '0;
         running_score_ff <= '0;
         previous_byte_ff <= '0;
         at_start_ff      <= 1'b1;
         rsp_valid_ff     <= 1'b0;
      end else begin
         pattern_ff       <= pattern_in;
         length_ff        <= length_in;
         in_valid_ff      <= in_valid_in;
         pattern_index_ff <= pattern_index_in;
         run_length_ff    <= run_length_in;
         running_score_ff <= running_score_in;
         previous_byte_ff <= previous_byte_in;
         at_start_ff      <= at_start_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_byte_ff   <= in_byte_in;
      in_has_ff    <= in_has_in;
      in_eot_ff    <= in_eot_in;
      rsp_score_ff <= rsp_score_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_score = rsp_score_ff;

   // input side only backs up behind a held result
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid_ff && rsp_stall && in_eot_ff))
      else $error("req_stall without a held result");

   a_index_bound: assert property (@(posedge clock) disable iff (reset)
      pattern_index_ff <= IDX_W'(MAX_PATTERN))
      else $error("pattern index beyond pattern depth");

   a_run_bound: assert property (@(posedge clock) disable iff (reset)
      run_length_ff <= RUN_W'(pattern_index_ff))
      else $error("run longer than matched prefix");

   a_text_clear: assert property (@(posedge clock) disable iff (reset)
      (item_go && in_eot_ff) |=> (pattern_index_ff == '0 && running_score_ff == '0 &&
                                  at_start_ff && rsp_valid_ff))
      else $error("text state not cleared after end of text");

endmodule
